// ----- rtl/core/dems_pkg.sv -----
// ----------------------------------------------------------------------------
// dems_pkg
// Shared types, constants and compare helpers for the directory record sorter.
// ----------------------------------------------------------------------------
package dems_pkg;

    localparam int MaxEntries = 64;
    localparam int KeySlots   = 4;
    localparam int NameLen    = 13;
    localparam int AddrW      = $clog2(MaxEntries);
    localparam int CntW       = $clog2(MaxEntries + 1);

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_SORT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] KEY_NAME = 3'd1;
    localparam logic [2:0] KEY_EXT  = 3'd2;
    localparam logic [2:0] KEY_DATE = 3'd3;
    localparam logic [2:0] KEY_SIZE = 3'd4;
    localparam logic [2:0] KEY_DIRS = 3'd5;

    localparam logic [1:0] REG_KEY_COUNT = 2'd0;
    localparam logic [1:0] REG_KEY_LIST  = 2'd1;
    localparam logic [1:0] REG_REV_MASK  = 2'd2;

    localparam logic [7:0] CharDot = 8'h2E;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] name_low;
        logic [39:0] name_high;
        logic [7:0]  attributes;
        logic [15:0] file_time;
        logic [15:0] file_date;
        logic [31:0] file_size;
    } t_req;

    typedef struct packed {
        logic [63:0] out_name_low;
        logic [39:0] out_name_high;
        logic [7:0]  out_attributes;
        logic [15:0] out_time;
        logic [15:0] out_date;
        logic [31:0] out_size;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [103:0] name;
        logic [7:0]   attr;
        logic [15:0]  ftime;
        logic [15:0]  fdate;
        logic [31:0]  fsize;
    } t_rec;

    typedef struct packed {
        logic [2:0]  key_count;
        logic [11:0] key_list;
        logic [3:0]  reverse_mask;
    } t_cfg;

    // Signed -1/0/1 as 2 bits: 2'b11 less, 2'b00 equal, 2'b01 greater.
    function automatic logic [1:0] cmp_str(input logic [103:0] a, input logic [3:0] pa,
                                           input logic [103:0] b, input logic [3:0] pb);
        logic [1:0] r;
        logic       done;
        logic [7:0] ca;
        logic [7:0] cb;
        logic [4:0] ia;
        logic [4:0] ib;
        r    = 2'b00;
        done = 1'b0;
        for (int i = 0; i < NameLen; i++) begin
            ia = 5'(pa) + 5'(i);
            ib = 5'(pb) + 5'(i);
            ca = (ia < 5'(NameLen)) ? a[ia*8 +: 8] : 8'h00;
            cb = (ib < 5'(NameLen)) ? b[ib*8 +: 8] : 8'h00;
            if (!done) begin
                if (ca != cb) begin
                    r    = (ca < cb) ? 2'b11 : 2'b01;
                    done = 1'b1;
                end else if (ca == 8'h00) begin
                    done = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] ext_start(input logic [103:0] a);
        logic [3:0] r;
        logic       done;
        r    = 4'(NameLen);
        done = 1'b0;
        for (int i = 0; i < NameLen; i++) begin
            if (!done) begin
                if (a[i*8 +: 8] == 8'h00) begin
                    r    = 4'(i);
                    done = 1'b1;
                end else if (a[i*8 +: 8] == CharDot) begin
                    r    = 4'(i + 1);
                    done = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/dems_cmp.sv -----
// ----------------------------------------------------------------------------
// dems_cmp
// Multi-key record comparator; flags when record a orders after record b.
// ----------------------------------------------------------------------------
module dems_cmp
    import dems_pkg::*;
(
    input  t_cfg i_cfg,
    input  t_rec i_a,
    input  t_rec i_b,
    output logic o_gt
);

    logic [1:0] name_r;
    logic [1:0] ext_r;
    logic [1:0] key_r [KeySlots];
    logic [2:0] n_keys;
    logic [1:0] res;
    logic       hit;
    logic       da;
    logic       db;

    always_comb begin
        name_r = cmp_str(i_a.name, 4'd0, i_b.name, 4'd0);
        ext_r  = cmp_str(i_a.name, ext_start(i_a.name), i_b.name, ext_start(i_b.name));
        da     = i_a.attr[4];
        db     = i_b.attr[4];
        for (int s = 0; s < KeySlots; s++) begin
            case (i_cfg.key_list[3*s +: 3])
                KEY_NAME: key_r[s] = name_r;
                KEY_EXT:  key_r[s] = (ext_r != 2'b00) ? ext_r : name_r;
                KEY_DATE: begin
                    if (i_a.fdate != i_b.fdate)
                        key_r[s] = (i_a.fdate < i_b.fdate) ? 2'b11 : 2'b01;
                    else if (i_a.ftime != i_b.ftime)
                        key_r[s] = (i_a.ftime < i_b.ftime) ? 2'b11 : 2'b01;
                    else
                        key_r[s] = 2'b00;
                end
                KEY_SIZE: begin
                    if (i_a.fsize == i_b.fsize) key_r[s] = 2'b00;
                    else key_r[s] = (i_a.fsize < i_b.fsize) ? 2'b11 : 2'b01;
                end
                KEY_DIRS: key_r[s] = (da && !db) ? 2'b11 : ((!da && db) ? 2'b01 : 2'b00);
                default:  key_r[s] = 2'b00;
            endcase
        end
        n_keys = (i_cfg.key_count > 3'(KeySlots)) ? 3'(KeySlots) : i_cfg.key_count;
        res = name_r;
        hit = 1'b0;
        for (int s = 0; s < KeySlots; s++) begin
            if (!hit && (3'(s) < n_keys) && key_r[s] != 2'b00) begin
                hit = 1'b1;
                res = i_cfg.reverse_mask[s] ? ((key_r[s] == 2'b01) ? 2'b11 : 2'b01) : key_r[s];
            end
        end
        o_gt = (res == 2'b01);
    end

endmodule

// ----- rtl/core/dems_ram.sv -----
// ----------------------------------------------------------------------------
// dems_ram
// Record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dems_ram
    import dems_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  t_rec             i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output t_rec             o_rdata
);

    t_rec mem [MaxEntries];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- rtl/core/directory_entry_multikey_sorter_core.sv -----
// ----------------------------------------------------------------------------
// directory_entry_multikey_sorter_core
// Stores directory records, exchange-sorts them by configured keys, emits them.
// ----------------------------------------------------------------------------
// Usage: a request is taken when i_start is high and o_busy is low.
// Store requests are dropped when the store is full; clear empties it. Sort
// holds o_busy for its whole run: record i is held in a register while each
// j > i is read from the single-port-read record memory (per pair: read, then
// compare and write back j on an exchange), then the held record is written
// back to slot i. Emission presents the records in order on o_res with
// o_res_valid high for one cycle, last set on the final record; the final
// record appears in the same cycle that o_busy drops.
// The receiver cannot stall; results are simply strobed.
// Reset clears the count, configuration and control; memory content is left
// as is and is never read before written. Configuration uses the APB port.
// ----------------------------------------------------------------------------
module directory_entry_multikey_sorter_core
    import dems_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_req        i_req,
    output logic        o_busy,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LDI   = 7'b0000010,
        S_RDJ   = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_RDO   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_WRI   = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    t_cfg             r_cfg;
    logic [CntW-1:0]  r_count, n_count;
    logic [CntW-1:0]  r_i, n_i;
    logic [CntW-1:0]  r_j, n_j;
    t_rec             r_reci, n_reci;
    logic             r_vld, n_vld;
    t_res             r_res, n_res;

    logic             we;
    logic [AddrW-1:0] waddr, raddr;
    t_rec             wdata, rdata;
    logic             gt;
    logic [103:0]     pname;
    logic             ended;
    logic             wr;

    dems_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dems_cmp u_cmp (
        .i_cfg (r_cfg),
        .i_a   (r_reci),
        .i_b   (rdata),
        .o_gt  (gt)
    );

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_KEY_COUNT: prdata = {29'd0, r_cfg.key_count};
            REG_KEY_LIST:  prdata = {20'd0, r_cfg.key_list};
            REG_REV_MASK:  prdata = {28'd0, r_cfg.reverse_mask};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        ended = 1'b0;
        pname = {i_req.name_high, i_req.name_low};
        for (int k = 0; k < NameLen; k++) begin
            if (ended) pname[k*8 +: 8] = 8'h00;
            if (pname[k*8 +: 8] == 8'h00) ended = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i     = r_i;
        n_j     = r_j;
        n_reci  = r_reci;
        n_vld   = 1'b0;
        n_res   = r_res;
        we      = 1'b0;
        waddr   = r_i[AddrW-1:0];
        wdata   = r_reci;
        raddr   = r_j[AddrW-1:0];
        case (r_state)
            S_IDLE: begin
                waddr = r_count[AddrW-1:0];
                wdata = '{name: pname, attr: i_req.attributes, ftime: i_req.file_time,
                          fdate: i_req.file_date, fsize: i_req.file_size};
                raddr = '0;
                if (i_start) begin
                    case (i_req.op)
                        OP_STORE: begin
                            if (r_count < CntW'(MaxEntries)) begin
                                we      = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_CLEAR: n_count = '0;
                        OP_SORT: begin
                            if (r_count != '0) begin
                                n_i     = '0;
                                n_state = S_LDI;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LDI: begin
                // read of entry i was issued with raddr=i the cycle before
                n_reci = rdata;
                n_j    = r_i + 1'b1;
                if (r_i + 1'b1 >= r_count) begin
                    n_i     = '0;
                    n_state = S_RDO;
                    raddr   = '0;
                end else begin
                    n_state = S_RDJ;
                    raddr   = AddrW'(r_i + 1'b1);
                end
            end
            S_RDJ: n_state = S_CMP;
            S_CMP: begin
                if (gt) begin
                    we     = 1'b1;
                    waddr  = r_j[AddrW-1:0];
                    wdata  = r_reci;
                    n_reci = rdata;
                end
                if (r_j + 1'b1 < r_count) begin
                    n_j     = r_j + 1'b1;
                    raddr   = AddrW'(r_j + 1'b1);
                    n_state = S_RDJ;
                end else begin
                    n_state = S_WRI;
                end
            end
            S_WRI: begin
                // write back held record i, fetch the next i
                we      = 1'b1;
                waddr   = r_i[AddrW-1:0];
                wdata   = r_reci;
                n_i     = r_i + 1'b1;
                raddr   = AddrW'(r_i + 1'b1);
                n_state = S_LDI;
            end
            S_RDO: begin
                raddr   = r_i[AddrW-1:0];
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_vld = 1'b1;
                n_res = '{out_name_low: rdata.name[63:0], out_name_high: rdata.name[103:64],
                          out_attributes: rdata.attr, out_time: rdata.ftime,
                          out_date: rdata.fdate, out_size: rdata.fsize,
                          last: (r_i + 1'b1 == r_count)};
                if (r_i + 1'b1 == r_count) begin
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + 1'b1;
                    raddr   = AddrW'(r_i + 1'b1);
                    n_state = S_RDO;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_vld   <= 1'b0;
            r_cfg   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_vld   <= n_vld;
            if (wr) begin
                case (paddr[3:2])
                    REG_KEY_COUNT: r_cfg.key_count    <= pwdata[2:0];
                    REG_KEY_LIST:  r_cfg.key_list     <= pwdata[11:0];
                    REG_REV_MASK:  r_cfg.reverse_mask <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_reci <= n_reci;
        r_res  <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_vld;
    assign o_res       = r_res;

endmodule
